// ===== hdl/tape_block_deframer_unit_defines.svh =====
// Assertion macros used by the tape block deframer checker.
`ifndef TAPE_BLOCK_DEFRAMER_UNIT_DEFINES_SVH
`define TAPE_BLOCK_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define TBD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tape block deframer: same-cycle check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define TBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tape block deframer: next-cycle check failed");

`endif

// ===== hdl/tbd_pkg.sv =====
// Types and constants shared by the tape block deframer modules.
package tbd_pkg;

    typedef enum logic [2:0] {
        PH_GAP   = 3'd0,
        PH_SKIP  = 3'd1,
        PH_SYNC2 = 3'd2,
        PH_TYPE  = 3'd3,
        PH_LEN   = 3'd4,
        PH_DATA  = 3'd5,
        PH_CHECK = 3'd6
    } phase_t;

    localparam logic [7:0] LEADER_BYTE = 8'h01;
    localparam logic [7:0] SYNC_FIRST  = 8'h3C;
    localparam logic [7:0] SYNC_SECOND = 8'h5A;
    localparam logic [7:0] LEN_OFFSET  = 8'd2;
    localparam logic [3:0] GAP_RESET   = 4'd5;
    localparam logic [3:0] GAP_MAX     = 4'd15;

    typedef struct packed {
        logic       valid;
        logic [7:0] tape_byte;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] block_type;
        logic [7:0] block_length;
        logic       checksum_ok;
        logic       last;
    } res_t;

endpackage

// ===== hdl/tape_block_deframer_unit.sv =====
// Top level of the tape block deframer.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_stall  | tape_byte
//  out     | out_valid / out_stall| kind, data_byte, block_type, block_length,
//          |                      | checksum_ok, last
//  cfg     | cfg_write            | cfg_data (gap length)
//
// One byte per cycle sustained while no stall holds the flow; the state machine takes one step per byte in a cycle.
// A result reaches the output through the input register, then the result register.
// Reset clears the state machine, the buffers and sets the gap length to 5.
// A stalled output holds its beat; one more byte fits in the skid entry, then in_stall rises.
module tape_block_deframer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [3:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] tape_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] data_byte,
    output logic [7:0] block_type,
    output logic [7:0] block_length,
    output logic       checksum_ok,
    output logic       last
);
    import tbd_pkg::*;

    logic [3:0] gap_length_reg;
    item_t      item;
    logic       has_result;
    res_t       res;
    res_t       out_res;
    logic       ob_free;
    logic       advance;
    logic       load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_length_reg <= GAP_RESET;
        end
        else if (cfg_write)
        begin
            gap_length_reg <= cfg_data;
        end
    end

    assign advance = item.valid && (!has_result || ob_free);
    assign load    = advance && has_result;

    tbd_istage u_istage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .tape_byte (tape_byte),
        .advance   (advance),
        .in_stall  (in_stall),
        .item      (item)
    );

    tbd_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .tape_byte  (item.tape_byte),
        .gap_length (gap_length_reg),
        .has_result (has_result),
        .res        (res)
    );

    tbd_ostage u_ostage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res       (res),
        .out_stall (out_stall),
        .free      (ob_free),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign data_byte    = out_res.data_byte;
    assign block_type   = out_res.block_type;
    assign block_length = out_res.block_length;
    assign checksum_ok  = out_res.checksum_ok;
    assign last         = out_res.last;

endmodule

// ===== hdl/tbd_istage.sv =====
// Input register with one skid entry so the input stall is registered.
module tbd_istage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [7:0]     tape_byte,
    input  logic           advance,
    output logic           in_stall,
    output tbd_pkg::item_t item
);
    import tbd_pkg::*;

    logic       ir_valid_reg;
    logic       ir_valid_next;
    logic [7:0] ir_byte_reg;
    logic [7:0] ir_byte_next;
    logic       skid_valid_reg;
    logic       skid_valid_next;
    logic [7:0] skid_byte_reg;
    logic [7:0] skid_byte_next;
    logic       in_acc;
    logic       ir_load;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;
    assign ir_load  = !ir_valid_reg || advance;

    always_comb
    begin
        ir_valid_next   = ir_valid_reg;
        ir_byte_next    = ir_byte_reg;
        skid_valid_next = skid_valid_reg;
        skid_byte_next  = skid_byte_reg;
        if (ir_load)
        begin
            if (skid_valid_reg)
            begin
                ir_valid_next   = 1'b1;
                ir_byte_next    = skid_byte_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                ir_valid_next = in_acc;
                ir_byte_next  = tape_byte;
            end
        end
        else if (in_acc)
        begin
            skid_valid_next = 1'b1;
            skid_byte_next  = tape_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            ir_valid_reg   <= ir_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ir_byte_reg   <= ir_byte_next;
        skid_byte_reg <= skid_byte_next;
    end

    assign item.valid     = ir_valid_reg;
    assign item.tape_byte = ir_byte_reg;

endmodule

// ===== hdl/tbd_fsm.sv =====
// Deframing state machine: gap hunt, sync, header, payload sum and checksum.
module tbd_fsm (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    tape_byte,
    input  logic [3:0]    gap_length,
    output logic          has_result,
    output tbd_pkg::res_t res
);
    import tbd_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] gap_count_reg;
    logic [3:0] gap_count_next;
    logic [7:0] remaining_reg;
    logic [7:0] remaining_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] type_reg;
    logic [7:0] type_next;
    logic [7:0] length_reg;
    logic [7:0] length_next;
    logic [3:0] need;
    logic [3:0] gap_inc;
    logic [7:0] len_calc;
    logic [7:0] check_sum;

    assign need      = (gap_length == 4'd0) ? 4'd1 : gap_length;
    assign gap_inc   = (gap_count_reg == GAP_MAX) ? GAP_MAX : gap_count_reg + 4'd1;
    assign len_calc  = tape_byte - LEN_OFFSET;
    assign check_sum = sum_reg + tape_byte;

    always_comb
    begin
        phase_next       = phase_reg;
        gap_count_next   = gap_count_reg;
        remaining_next   = remaining_reg;
        sum_next         = sum_reg;
        type_next        = type_reg;
        length_next      = length_reg;
        has_result       = 1'b0;
        res.kind         = 1'b0;
        res.data_byte    = 8'd0;
        res.block_type   = type_reg;
        res.block_length = length_reg;
        res.checksum_ok  = 1'b0;
        res.last         = 1'b0;
        case (phase_reg)
            PH_SKIP:
            begin
                if (tape_byte != LEADER_BYTE)
                begin
                    if (tape_byte == SYNC_FIRST)
                    begin
                        phase_next = PH_SYNC2;
                    end
                    else
                    begin
                        phase_next     = PH_GAP;
                        gap_count_next = 4'd0;
                    end
                end
            end
            PH_SYNC2:
            begin
                if (tape_byte == SYNC_SECOND)
                begin
                    phase_next = PH_TYPE;
                end
                else
                begin
                    phase_next     = PH_GAP;
                    gap_count_next = 4'd0;
                end
            end
            PH_TYPE:
            begin
                type_next  = tape_byte;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                length_next    = len_calc;
                remaining_next = len_calc;
                sum_next       = 8'd0;
                phase_next     = (len_calc == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA:
            begin
                has_result     = 1'b1;
                res.data_byte  = tape_byte;
                sum_next       = check_sum;
                remaining_next = remaining_reg - 8'd1;
                if (remaining_reg == 8'd1)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                has_result      = 1'b1;
                res.kind        = 1'b1;
                res.checksum_ok = (check_sum == 8'd0);
                res.last        = 1'b1;
                phase_next      = PH_GAP;
                gap_count_next  = 4'd0;
            end
            default:
            begin
                if (tape_byte == LEADER_BYTE)
                begin
                    if (gap_inc >= need)
                    begin
                        phase_next     = PH_SKIP;
                        gap_count_next = 4'd0;
                    end
                    else
                    begin
                        phase_next     = PH_GAP;
                        gap_count_next = gap_inc;
                    end
                end
                else
                begin
                    phase_next     = PH_GAP;
                    gap_count_next = 4'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_GAP;
            gap_count_reg <= 4'd0;
            remaining_reg <= 8'd0;
            sum_reg       <= 8'd0;
            type_reg      <= 8'd0;
            length_reg    <= 8'd0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            gap_count_reg <= gap_count_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            type_reg      <= type_next;
            length_reg    <= length_next;
        end
    end

endmodule

// ===== hdl/tbd_ostage.sv =====
// Result register that holds a beat while the output is stalled.
module tbd_ostage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  tbd_pkg::res_t res,
    input  logic          out_stall,
    output logic          free,
    output logic          out_valid,
    output tbd_pkg::res_t out_res
);
    import tbd_pkg::*;

    logic ob_valid_reg;
    logic ob_valid_next;
    res_t ob_res_reg;

    assign free = !ob_valid_reg || !out_stall;

    always_comb
    begin
        ob_valid_next = ob_valid_reg;
        if (load)
        begin
            ob_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ob_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            ob_valid_reg <= ob_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ob_res_reg <= res;
        end
    end

    assign out_valid = ob_valid_reg;
    assign out_res   = ob_res_reg;

endmodule

// ===== hdl/tbd_checker.sv =====
// Port-level checks for the tape block deframer, bound to the top level.
`include "tape_block_deframer_unit_defines.svh"

module tbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       kind,
    input logic [7:0] data_byte,
    input logic [7:0] block_type,
    input logic [7:0] block_length,
    input logic       checksum_ok,
    input logic       last
);

    `TBD_ASSERT_NOW(a_end_record_shape, out_valid && kind, last && (data_byte == 8'd0))
    `TBD_ASSERT_NOW(a_payload_shape, out_valid && !kind, !last && !checksum_ok)
    `TBD_ASSERT_NEXT(a_out_hold_valid, out_valid && out_stall, out_valid)
    `TBD_ASSERT_NEXT(a_out_hold_data, out_valid && out_stall,
        $stable(data_byte) && $stable(kind) && $stable(block_type) && $stable(block_length))

endmodule

bind tape_block_deframer_unit tbd_checker u_tbd_checker (.*);

// ===== tb/sv/tape_block_deframer_unit_test.sv =====
// Self-checking testbench for the tape block deframer: directed and random cassette streams.
`timescale 1ns / 100ps

module tape_block_deframer_unit_test;

    import tbd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 200;

    class deframe_board;
        logic [3:0] gap_len;
        phase_t     phase;
        logic [3:0] gap_count;
        logic [7:0] left;
        logic [7:0] sum;
        logic [7:0] cur_type;
        logic [7:0] cur_len;
        res_t       record_q[$];
        int         errors;

        function new();
            gap_len   = GAP_RESET;
            phase     = PH_GAP;
            gap_count = '0;
            left      = '0;
            sum       = '0;
            cur_type  = '0;
            cur_len   = '0;
            errors    = 0;
        endfunction

        function void set_gap(logic [3:0] v);
            gap_len = v;
        endfunction

        function int pending();
            return record_q.size();
        endfunction

        function void restart();
            phase     = PH_GAP;
            gap_count = '0;
        endfunction

        function void push_record(logic k, logic [7:0] d, logic ok);
            res_t r;
            r.kind         = k;
            r.data_byte    = d;
            r.block_type   = cur_type;
            r.block_length = cur_len;
            r.checksum_ok  = ok;
            r.last         = k;
            record_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            logic [3:0] need;
            logic [7:0] total;
            need = (gap_len == 4'd0) ? 4'd1 : gap_len;
            case (phase)
                PH_SKIP:
                begin
                    if (b != LEADER_BYTE)
                    begin
                        if (b == SYNC_FIRST)
                            phase = PH_SYNC2;
                        else
                            restart();
                    end
                end
                PH_SYNC2:
                begin
                    if (b == SYNC_SECOND)
                        phase = PH_TYPE;
                    else
                        restart();
                end
                PH_TYPE:
                begin
                    cur_type = b;
                    phase    = PH_LEN;
                end
                PH_LEN:
                begin
                    cur_len = b - LEN_OFFSET;
                    left    = cur_len;
                    sum     = '0;
                    phase   = (left == 8'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA:
                begin
                    sum  = sum + b;
                    left = left - 8'd1;
                    if (left == 8'd0)
                        phase = PH_CHECK;
                    push_record(1'b0, b, 1'b0);
                end
                PH_CHECK:
                begin
                    total = sum + b;
                    push_record(1'b1, 8'd0, total == 8'd0);
                    restart();
                end
                default:
                begin
                    if (b == LEADER_BYTE)
                    begin
                        if (gap_count < GAP_MAX)
                            gap_count = gap_count + 4'd1;
                        if (gap_count >= need)
                        begin
                            phase     = PH_SKIP;
                            gap_count = '0;
                        end
                        else
                            phase = PH_GAP;
                    end
                    else
                        restart();
                end
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(res_t got);
            res_t want;
            if (record_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual kind %h data %h",
                         $time, got.kind, got.data_byte);
                errors++;
            end
            else
            begin
                want = record_q.pop_front();
                compare_field("kind", {7'd0, want.kind}, {7'd0, got.kind});
                compare_field("data_byte", want.data_byte, got.data_byte);
                compare_field("block_type", want.block_type, got.block_type);
                compare_field("block_length", want.block_length, got.block_length);
                compare_field("checksum_ok", {7'd0, want.checksum_ok}, {7'd0, got.checksum_ok});
                compare_field("last", {7'd0, want.last}, {7'd0, got.last});
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic [3:0] cfg_data = 4'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] tape_byte = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] block_type;
    logic [7:0] block_length;
    logic       checksum_ok;
    logic       last;

    deframe_board board = new();

    int cycle_count = 0;
    int sent_count  = 0;
    int burst_left  = 0;
    bit idle_on     = 1'b1;
    int gap_setting = int'(GAP_RESET);
    int block_count = 0;
    int stall_mode  = 0;
    int stall_timer = 0;

    tape_block_deframer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .tape_byte    (tape_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .block_type   (block_type),
        .block_length (block_length),
        .checksum_ok  (checksum_ok),
        .last         (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(50, 300);
        end
        else
            stall_timer <= stall_timer - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            2:       out_stall <= ((stall_timer % 7) < 4);
            default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    always @(posedge clk)
    begin : watch_out
        res_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind         = kind;
            got.data_byte    = data_byte;
            got.block_type   = block_type;
            got.block_length = block_length;
            got.checksum_ok  = checksum_ok;
            got.last         = last;
            board.check_beat(got);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int gap_need();
        return (gap_setting == 0) ? 1 : gap_setting;
    endfunction

    function automatic logic [7:0] byte_other_than(logic [7:0] a, logic [7:0] b);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        while (v == a || v == b)
            v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        if (idle_on && burst_left == 0)
        begin
            gap        = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        in_valid  <= 1'b1;
        tape_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_byte(b);
        sent_count++;
    endtask

    task automatic send_leaders(int n);
        repeat (n) send_byte(LEADER_BYTE);
    endtask

    task automatic send_block(logic [7:0] len_byte, bit good_sum);
        logic [7:0] count;
        logic [7:0] total;
        logic [7:0] b;
        send_leaders(gap_need() + $urandom_range(0, 3));
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(len_byte);
        count = len_byte - LEN_OFFSET;
        total = 8'd0;
        repeat (count)
        begin
            b     = 8'($urandom_range(0, 255));
            total = total + b;
            send_byte(b);
        end
        if (good_sum)
            send_byte(8'd0 - total);
        else
            send_byte(8'($urandom_range(0, 255)));
        block_count++;
    endtask

    task automatic write_gap(logic [3:0] v);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_gap(v);
        gap_setting = int'(v);
    endtask

    initial
    begin
        logic [3:0] settings[7];
        logic [7:0] len_byte;
        int         phase_end;
        int         pick;

        settings = '{4'd15, 4'd0, 4'd3, 4'd1, 4'd7, 4'd15, 4'd2};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gap length, extra leader skipped, extreme type and payload, good checksum
        send_leaders(6);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'hFF);
        send_byte(8'h04);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);

        // wrong first sync, wrong second sync, empty block with bad checksum
        write_gap(4'd1);
        send_byte(LEADER_BYTE);
        send_byte(8'h77);
        send_byte(LEADER_BYTE);
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        send_byte(LEADER_BYTE);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h80);

        for (int p = 0; p < 8; p++)
        begin
            if (p < 7)
                write_gap(settings[p]);
            else
                write_gap(4'($urandom_range(0, 15)));
            idle_on   = (p != 2);
            phase_end = sent_count + PHASE_ITEMS;
            while (sent_count < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    if (block_count == 4)
                        len_byte = 8'd0;
                    else if (block_count == 30)
                        len_byte = 8'd1;
                    else if ($urandom_range(0, 9) < 8)
                        len_byte = 8'($urandom_range(2, 12));
                    else
                        len_byte = 8'($urandom_range(13, 40));
                    send_block(len_byte, $urandom_range(0, 3) != 0);
                end
                else if (pick < 85)
                begin
                    send_leaders(gap_need() + $urandom_range(0, 2));
                    if ($urandom_range(0, 1))
                        send_byte(byte_other_than(SYNC_FIRST, LEADER_BYTE));
                    else
                    begin
                        send_byte(SYNC_FIRST);
                        send_byte(byte_other_than(SYNC_SECOND, SYNC_SECOND));
                    end
                end
                else if (pick < 95)
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                else
                begin
                    if (gap_need() > 1)
                        send_leaders(gap_need() - 1);
                    send_byte(byte_other_than(LEADER_BYTE, LEADER_BYTE));
                end
            end
            send_leaders($urandom_range(0, 3));
        end

        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
